### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while reset is low.
`define ACS_ASSERT_CLK(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Assert a property on clk with reset arst_n.
`define ACS_ASSERT(lbl, prop) `ACS_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

### rtl/acs_pkg.sv
`timescale 1ns / 1ps
package acs_pkg;

	localparam int ROUND_COUNT = 10;
	localparam int HALF_W      = 64;
	localparam int BLOCK_W     = 128;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = 3;
	localparam int BLOCK_BYTES = 16;

	localparam logic [IDX_W-1:0] REG_KEY_HIGH = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_IV_HIGH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_IV_LOW   = 3'd3;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY    = 8'h1b;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Byte i of the block sits at bits [127-8i -: 8]; byte 4c+r is row r, column c.
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)&3)+r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] a);
		logic [7:0] a0, a1, a2, a3, all;
		a0  = a[31:24];
		a1  = a[23:16];
		a2  = a[15:8];
		a3  = a[7:0];
		all = a0 ^ a1 ^ a2 ^ a3;
		return {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
			a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			t[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
		end
		return t;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
		logic [31:0] t, n0, n1, n2, n3;
		t  = sub_word({rk[23:0], rk[31:24]}) ^ {rcon, 24'h000000};
		n0 = rk[127:96] ^ t;
		n1 = rk[95:64] ^ n0;
		n2 = rk[63:32] ^ n1;
		n3 = rk[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

### rtl/acs_if.sv
`timescale 1ns / 1ps
interface acs_in_if;
	logic                       valid;
	logic                       ready;
	logic [acs_pkg::HALF_W-1:0] data_high;
	logic [acs_pkg::HALF_W-1:0] data_low;
	logic [acs_pkg::CNT_W-1:0]  valid_bytes;
	logic                       message_end;

	modport source (output valid, data_high, data_low, valid_bytes, message_end, input ready);
	modport sink (input valid, data_high, data_low, valid_bytes, message_end, output ready);
endinterface

interface acs_out_if;
	logic                       valid;
	logic                       ready;
	logic [acs_pkg::HALF_W-1:0] result_high;
	logic [acs_pkg::HALF_W-1:0] result_low;
	logic [acs_pkg::CNT_W-1:0]  result_bytes;
	logic                       result_end;

	modport source (output valid, result_high, result_low, result_bytes, result_end, input ready);
	modport sink (input valid, result_high, result_low, result_bytes, result_end, output ready);
endinterface

### rtl/aes128_ctr_stream_crypt.sv
`timescale 1ns / 1ps
// An input beat is run through the round unit one round at a time, then held as the result beat.
// A new block is taken only once the last result beat is taken; the shared round unit runs one round a cycle
// and reads one round key a cycle from the round-key RAM.
// Reset: key schedule expanded from the all-zero key, input held off meanwhile; every key write
// repeats that expansion. Counter and reload flag clear on reset.
module aes128_ctr_stream_crypt #(
	parameter int ROUND_COUNT = acs_pkg::ROUND_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [acs_pkg::IDX_W-1:0]   cfg_index,
	input  logic [acs_pkg::HALF_W-1:0]  cfg_data,
	acs_in_if.sink                      din,
	acs_out_if.source                   dout
);
	localparam int NRK = ROUND_COUNT + 1;
	localparam int AW = $clog2(NRK);
	localparam logic [AW-1:0] LAST = AW'(ROUND_COUNT);
	localparam int BW = acs_pkg::BLOCK_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [acs_pkg::HALF_W-1:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic                       kick_q;

	// Counter state
	logic [BW-1:0] ctr_q;
	logic          loaded_q;

	// Block in flight
	logic [BW-1:0]                 st_q;
	logic [BW-1:0]                 data_q;
	logic [acs_pkg::BLOCK_BYTES-1:0] mask_q;
	logic [acs_pkg::CNT_W-1:0]     bytes_q;
	logic                          end_q;
	logic [AW-1:0]                 round_q;

	// Key RAM ports
	logic          kx_busy, kx_we;
	logic [AW-1:0] kx_addr, rd_addr;
	logic [BW-1:0] kx_data, rk;

	logic                          in_acc;
	logic [BW-1:0]                 ctr_use;
	logic [acs_pkg::CNT_W-1:0]     nb;
	logic [acs_pkg::BLOCK_BYTES-1:0] mask_d;
	logic [BW-1:0]                 bmask, result;

	// Register writes; a key write kicks a new expansion on the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			kick_q     <= 1'b1;
		end else begin
			kick_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					acs_pkg::REG_KEY_HIGH: begin
						key_high_q <= cfg_data;
						kick_q     <= 1'b1;
					end
					acs_pkg::REG_KEY_LOW: begin
						key_low_q <= cfg_data;
						kick_q    <= 1'b1;
					end
					acs_pkg::REG_IV_HIGH: iv_high_q <= cfg_data;
					acs_pkg::REG_IV_LOW:  iv_low_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	acs_keyexp #(.ROUND_COUNT(ROUND_COUNT)) u_keyexp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (kick_q),
		.key     ({key_high_q, key_low_q}),
		.busy    (kx_busy),
		.wr_en   (kx_we),
		.wr_addr (kx_addr),
		.wr_data (kx_data)
	);

	acs_ram #(.WIDTH(BW), .DEPTH(NRK)) u_rk_ram (
		.clk   (clk),
		.we    (kx_we),
		.waddr (kx_addr),
		.wdata (kx_data),
		.raddr (rd_addr),
		.rdata (rk)
	);

	assign din.ready = (state_q == ST_IDLE) && !kx_busy;
	assign in_acc    = din.valid && din.ready;

	// First block of a message takes the IV; later blocks take the running counter.
	assign ctr_use = loaded_q ? ctr_q : {iv_high_q, iv_low_q};

	// Saturate the byte count and build the keep mask, byte 0 in the top bit.
	always_comb begin
		nb = (din.valid_bytes > acs_pkg::CNT_W'(acs_pkg::BLOCK_BYTES))
			? acs_pkg::CNT_W'(acs_pkg::BLOCK_BYTES) : din.valid_bytes;
		for (int i = 0; i < acs_pkg::BLOCK_BYTES; i++) begin
			mask_d[acs_pkg::BLOCK_BYTES-1-i] = (acs_pkg::CNT_W'(i) < nb);
		end
	end

	// Fetch key 0 on accept, then the key for the next round each cycle.
	assign rd_addr = (state_q == ST_RUN && round_q != LAST) ? round_q + 1'b1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			round_q  <= '0;
			ctr_q    <= '0;
			loaded_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						round_q <= '0;
						// Advance the counter, or mark it for reload at message end.
						if (din.message_end) begin
							loaded_q <= 1'b0;
						end else begin
							ctr_q    <= ctr_use + BW'(1);
							loaded_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					round_q <= round_q + 1'b1;
					if (round_q == LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (dout.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Round datapath: initial key add, middle rounds, final round without mix.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_q    <= ctr_use;
			data_q  <= {din.data_high, din.data_low};
			mask_q  <= mask_d;
			bytes_q <= nb;
			end_q   <= din.message_end;
		end else if (state_q == ST_RUN) begin
			if (round_q == '0) begin
				st_q <= st_q ^ rk;
			end else if (round_q == LAST) begin
				st_q <= acs_pkg::sub_shift(st_q) ^ rk;
			end else begin
				st_q <= acs_pkg::mix_columns(acs_pkg::sub_shift(st_q)) ^ rk;
			end
		end
	end

	// Drop bytes beyond the valid count.
	always_comb begin
		for (int i = 0; i < acs_pkg::BLOCK_BYTES; i++) begin
			bmask[8*i +: 8] = {8{mask_q[i]}};
		end
		result = (data_q ^ st_q) & bmask;
	end

	assign dout.valid        = (state_q == ST_OUT);
	assign dout.result_high  = result[BW-1:acs_pkg::HALF_W];
	assign dout.result_low   = result[acs_pkg::HALF_W-1:0];
	assign dout.result_bytes = bytes_q;
	assign dout.result_end   = end_q;
endmodule

### rtl/acs_ram.sv
`timescale 1ns / 1ps
module acs_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/acs_keyexp.sv
`timescale 1ns / 1ps
module acs_keyexp #(
	parameter int ROUND_COUNT = acs_pkg::ROUND_COUNT,
	localparam int NRK = ROUND_COUNT + 1,
	localparam int AW = $clog2(NRK)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [acs_pkg::BLOCK_W-1:0] key,
	output logic                        busy,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [acs_pkg::BLOCK_W-1:0] wr_data
);
	localparam logic [AW-1:0] LAST = AW'(NRK - 1);

	logic                        busy_q;
	logic [AW-1:0]               idx_q;
	logic [acs_pkg::BLOCK_W-1:0] rk_q;
	logic [7:0]                  rcon_q;

	// Write one round key a cycle, derive the next from it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rk_q   <= key;
			rcon_q <= acs_pkg::RCON_FIRST;
		end else if (busy_q) begin
			rk_q   <= acs_pkg::key_next(rk_q, rcon_q);
			rcon_q <= acs_pkg::xtime(rcon_q);
		end
	end

	assign busy    = busy_q | start;
	assign wr_en   = busy_q;
	assign wr_addr = idx_q;
	assign wr_data = rk_q;
endmodule

### rtl/acs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [acs_pkg::HALF_W-1:0] result_high,
	input logic [acs_pkg::HALF_W-1:0] result_low,
	input logic [acs_pkg::CNT_W-1:0]  result_bytes
);
	`ACS_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid)
	`ACS_ASSERT(a_bytes_range, out_valid |-> result_bytes <= 5'd16)
	`ACS_ASSERT(a_zero_empty, out_valid && result_bytes == 5'd0 |-> result_high == 64'd0 && result_low == 64'd0)
	`ACS_ASSERT(a_no_early_result, in_valid && in_ready |=> !out_valid)
	`ACS_ASSERT(a_no_accept_busy, out_valid |-> !in_ready)
endmodule

bind aes128_ctr_stream_crypt acs_checker u_acs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.result_high  (dout.result_high),
	.result_low   (dout.result_low),
	.result_bytes (dout.result_bytes)
);
